@@ sv/thlm_pkg.sv @@
// Shared types and codes for the hierarchical lock manager.
// Used by tree_hierarchical_lock_manager; no dependencies.
package thlm_pkg;

  localparam int NODE_W  = 8;
  localparam int COUNT_W = 8;

  localparam logic [1:0] KIND_ATTACH = 2'd0;
  localparam logic [1:0] KIND_LOCK   = 2'd1;
  localparam logic [1:0] KIND_UNLOCK = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_SELF_BUSY = 2'd1;
  localparam logic [1:0] ST_ANC_BUSY  = 2'd2;
  localparam logic [1:0] ST_NOT_HELD  = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic               pvalid;
    logic [NODE_W-1:0]  link;
    logic               lock;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ sv/thlm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module thlm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tree_hierarchical_lock_manager.sv @@
// Hierarchical lock manager: per-node table in thlm_ram, one sequencer walking ancestors.
// Depends on thlm_pkg and thlm_ram.
// Each ancestor visited on a walk takes a table read and then a check or adjust step, and a
// granted lock adds a flag write; all of these go through the one table RAM in turn.
// One item at a time: a new transfer is taken only in idle, which is entered as the result is registered.
// Reset clears the per-entry valid flags at once, so every node reads as an unlocked root.
module tree_hierarchical_lock_manager #(
  parameter int NODES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // node[7:0], has_parent[8], parent_node[16:9], zeros
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // locked[0], locked_descendants[8:1], zeros
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int DEPTH = (NODES < 256) ? NODES : 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(NODES + 1);
  localparam int NW    = thlm_pkg::NODE_W;
  localparam int CW    = thlm_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_NODE, S_SET, S_WRD, S_WEV, S_FRD, S_FEV
  } state_e;

  state_e               state_q, state_d;
  logic [1:0]           kind_q, kind_d;
  logic [NW-1:0]        node_q, node_d;
  logic                 hp_q, hp_d;
  logic [NW-1:0]        pn_q, pn_d;
  logic                 oor_q, oor_d;
  logic [1:0]           status_q, status_d;
  thlm_pkg::entry_t     ne_q, ne_d;
  logic [AW-1:0]        at_q, at_d;
  logic [SW-1:0]        steps_q, steps_d;
  logic                 chk_q, chk_d;
  logic                 inc_q, inc_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q, out_status_d;
  logic                 out_locked_q, out_locked_d;
  logic [CW-1:0]        out_cnt_q, out_cnt_d;
  logic [DEPTH-1:0]     vld_q, vld_d;
  logic                 rd_vld_q;

  logic                 we;
  logic [AW-1:0]        waddr;
  thlm_pkg::entry_t     wentry;
  logic [AW-1:0]        raddr;
  logic [thlm_pkg::ENTRY_W-1:0] rdata;
  thlm_pkg::entry_t     e;
  thlm_pkg::entry_t     up_src;
  logic                 up_ok;
  logic [AW-1:0]        up_at;
  logic                 steps_left;
  logic [AW-1:0]        node_idx;
  logic                 in_fire;

  thlm_ram #(
    .WIDTH(thlm_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wentry),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign e          = rd_vld_q ? thlm_pkg::entry_t'(rdata) : '0;
  assign up_src     = (state_q == S_SET) ? ne_q : e;
  assign up_ok      = up_src.pvalid && (32'(up_src.link) < NODES);
  assign up_at      = up_src.link[AW-1:0];
  assign steps_left = steps_q < SW'(NODES);
  assign node_idx   = node_q[AW-1:0];
  assign in_fire    = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'b0, out_cnt_q, out_locked_q};

  always_comb begin
    unique case (state_q)
      S_IDLE:  raddr = s_axis_tdata[AW-1:0];
      S_WRD:   raddr = at_q;
      default: raddr = node_idx;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    node_d       = node_q;
    hp_d         = hp_q;
    pn_d         = pn_q;
    oor_d        = oor_q;
    status_d     = status_q;
    ne_d         = ne_q;
    at_d         = at_q;
    steps_d      = steps_q;
    chk_d        = chk_q;
    inc_d        = inc_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_locked_d = out_locked_q;
    out_cnt_d    = out_cnt_q;
    vld_d        = vld_q;
    we           = 1'b0;
    waddr        = node_idx;
    wentry       = e;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          kind_d   = s_axis_tuser;
          node_d   = s_axis_tdata[7:0];
          hp_d     = s_axis_tdata[8];
          pn_d     = s_axis_tdata[16:9];
          oor_d    = !(32'(s_axis_tdata[7:0]) < NODES);
          status_d = thlm_pkg::ST_DONE;
          state_d  = (32'(s_axis_tdata[7:0]) < NODES) ? S_NODE : S_FRD;
        end
      end
      S_NODE: begin
        state_d = S_FRD;
        unique case (kind_q)
          thlm_pkg::KIND_ATTACH: begin
            we = 1'b1;
            wentry = '0;
            if (hp_q && (32'(pn_q) < NODES)) begin
              wentry.pvalid = 1'b1;
              wentry.link   = pn_q;
            end
            vld_d[node_idx] = 1'b1;
          end
          thlm_pkg::KIND_LOCK: begin
            if (e.lock || (e.count != '0)) begin
              status_d = thlm_pkg::ST_SELF_BUSY;
            end else begin
              ne_d = e;
              if (up_ok) begin
                at_d    = up_at;
                steps_d = SW'(1);
                chk_d   = 1'b1;
                state_d = S_WRD;
              end else begin
                state_d = S_SET;
              end
            end
          end
          thlm_pkg::KIND_UNLOCK: begin
            if (!e.lock) begin
              status_d = thlm_pkg::ST_NOT_HELD;
            end else begin
              we = 1'b1;
              wentry = e;
              wentry.lock = 1'b0;
              vld_d[node_idx] = 1'b1;
              if (up_ok) begin
                at_d    = up_at;
                steps_d = SW'(1);
                chk_d   = 1'b0;
                inc_d   = 1'b0;
                state_d = S_WRD;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_SET: begin
        we = 1'b1;
        wentry = ne_q;
        wentry.lock = 1'b1;
        vld_d[node_idx] = 1'b1;
        if (up_ok) begin
          at_d    = up_at;
          steps_d = SW'(1);
          chk_d   = 1'b0;
          inc_d   = 1'b1;
          state_d = S_WRD;
        end else begin
          state_d = S_FRD;
        end
      end
      S_WRD: begin
        state_d = S_WEV;
      end
      S_WEV: begin
        if (chk_q) begin
          if (e.lock) begin
            status_d = thlm_pkg::ST_ANC_BUSY;
            state_d  = S_FRD;
          end else if (steps_left && up_ok) begin
            at_d    = up_at;
            steps_d = SW'(steps_q + 1'b1);
            state_d = S_WRD;
          end else begin
            state_d = S_SET;
          end
        end else begin
          we = 1'b1;
          waddr = at_q;
          wentry = e;
          if (inc_q) begin
            if (e.count != thlm_pkg::COUNT_MAX) begin
              wentry.count = CW'(e.count + 1'b1);
            end
          end else if (e.count != '0) begin
            wentry.count = CW'(e.count - 1'b1);
          end
          vld_d[at_q] = 1'b1;
          if (steps_left && up_ok) begin
            at_d    = up_at;
            steps_d = SW'(steps_q + 1'b1);
            state_d = S_WRD;
          end else begin
            state_d = S_FRD;
          end
        end
      end
      S_FRD: begin
        state_d = S_FEV;
      end
      S_FEV: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = oor_q ? thlm_pkg::ST_DONE : status_q;
          out_locked_d = oor_q ? 1'b0 : e.lock;
          out_cnt_d    = oor_q ? '0 : e.count;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
      rd_vld_q    <= vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    node_q       <= node_d;
    hp_q         <= hp_d;
    pn_q         <= pn_d;
    oor_q        <= oor_d;
    status_q     <= status_d;
    ne_q         <= ne_d;
    at_q         <= at_d;
    steps_q      <= steps_d;
    chk_q        <= chk_d;
    inc_q        <= inc_d;
    out_status_q <= out_status_d;
    out_locked_q <= out_locked_d;
    out_cnt_q    <= out_cnt_d;
  end

endmodule
